// ===== rtl/core/bitmap_block_allocator_unit_defines.svh =====
// Assertion macros for the bitmap block allocator.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
// The consequent holds in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/bba_pkg.sv =====
// Package for the bitmap block allocator: constants, state enum and step structs.
// No dependencies.
package bba_pkg;
  localparam int NumBlocksDef = 4096;
  localparam int BlkW = 13;

  typedef enum logic [1:0] {
    ModeAlloc   = 2'd0,
    ModeFree    = 2'd1,
    ModeRelease = 2'd2,
    ModeReserve = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StAllocRd,
    StAllocScan,
    StRangeRd,
    StRangeWr,
    StDone
  } state_e;

  typedef struct packed {
    logic [7:0]      bits;
    logic [BlkW-1:0] pos0;
    logic [BlkW-1:0] run;
    logic [BlkW-1:0] rs;
    logic [BlkW-1:0] count;
    logic [BlkW-1:0] total;
  } scan_in_t;

  typedef struct packed {
    logic [BlkW-1:0] run;
    logic [BlkW-1:0] rs;
    logic            found;
    logic            last;
  } scan_out_t;
endpackage

// ===== rtl/core/bba_bitmap_mem.sv =====
// Bitmap word memory with one address port and registered read data.
// Depends on nothing but its parameters.
module bba_bitmap_mem #(
  parameter int Words = 128,
  parameter int AddrW = 7
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic             we_i,
  input  logic [31:0]      wdata_i,
  output logic [31:0]      rdata_o
);
  logic [31:0] mem [Words];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/core/bba_scan_step.sv =====
// First-fit run search over eight bitmap bits in one step.
// Depends on bba_pkg.
module bba_scan_step
  import bba_pkg::*;
(
  input  scan_in_t  step_i,
  output scan_out_t step_o
);
  always_comb begin
    logic [BlkW:0]   p;
    logic [BlkW-1:0] run;
    logic [BlkW-1:0] rs;
    logic            found;
    run   = step_i.run;
    rs    = step_i.rs;
    found = 1'b0;
    for (int k = 0; k < 8; k++) begin
      p = {1'b0, step_i.pos0} + (BlkW+1)'(k);
      if (!found && p < {1'b0, step_i.total}) begin
        if (step_i.bits[k]) begin
          run = '0;
        end else begin
          if (run == '0) begin
            rs = p[BlkW-1:0];
          end
          run = run + 1'b1;
          if (run == step_i.count) begin
            found = 1'b1;
          end
        end
      end
    end
    step_o.run   = run;
    step_o.rs    = rs;
    step_o.found = found;
    step_o.last  = ({1'b0, step_i.pos0} + (BlkW+1)'(8)) >= {1'b0, step_i.total};
  end
endmodule

// ===== rtl/core/bitmap_block_allocator_unit.sv =====
// Top level of the bitmap block allocator: sequencer, counters and result register.
// Depends on bba_pkg, bba_bitmap_mem, bba_scan_step and the assertion macro header.
//
// Channel   Direction  Handshake
// in        input      in_valid_i / in_stall_o
// out       output     out_valid_o / out_stall_i
// cfg       input      cfg_we_i (write only)
//
// A request is taken only when the block is idle; one result follows per request.
// Allocate reads one bitmap word at a time (one read, then up to four byte steps),
// then marks the found run with a read and a write per touched word.
// Free, release and reserve read and write each touched word through the single memory port.
// After reset a clearing pass sets every word before requests are taken.
// A held result stalls the block until it is taken.
`include "bitmap_block_allocator_unit_defines.svh"
module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MaxBlocks = NumBlocksDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      mode_i,
  input  logic [11:0]     start_block_i,
  input  logic [12:0]     block_count_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            ok_o,
  output logic [11:0]     result_block_o,
  output logic [12:0]     used_count_o,
  input  logic            cfg_we_i,
  input  logic [12:0]     cfg_data_i
);
  localparam int Words = (MaxBlocks + 31) / 32;
  localparam int AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam logic [BlkW-1:0] ResetTotal =
    BlkW'((MaxBlocks < 4096) ? MaxBlocks : 4096);

  state_e state_q, state_d;
  logic [BlkW-1:0] total_q, used_q, used_d;
  logic [BlkW-1:0] blk_q, blk_d, run_q, run_d, rs_q, rs_d;
  logic [BlkW-1:0] lo_q, lo_d, hi_q, hi_d, cnt_q, cnt_d;
  logic [1:0]      bsel_q, bsel_d;
  logic            set_q, set_d, ok_q, ok_d;
  logic [11:0]     res_q, res_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] addr;
  logic            we;
  logic [31:0]     wdata, rdata, mask;
  scan_in_t        scan_in;
  scan_out_t       scan_out;
  logic [BlkW-1:0] cfg_t;

  bba_bitmap_mem #(.Words(Words), .AddrW(AddrW)) u_mem (
    .clk_i  (clk_i),
    .addr_i (addr),
    .we_i   (we),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign scan_in.bits  = rdata[{bsel_q, 3'b000} +: 8];
  assign scan_in.pos0  = blk_q + BlkW'({bsel_q, 3'b000});
  assign scan_in.run   = run_q;
  assign scan_in.rs    = rs_q;
  assign scan_in.count = cnt_q;
  assign scan_in.total = total_q;

  bba_scan_step u_step (
    .step_i(scan_in),
    .step_o(scan_out)
  );

  always_comb begin
    logic [BlkW:0] b;
    for (int j = 0; j < 32; j++) begin
      b = {1'b0, blk_q} + (BlkW+1)'(j);
      mask[j] = (b >= {1'b0, lo_q}) && (b < {1'b0, hi_q});
    end
  end

  always_comb begin
    cfg_t = (cfg_data_i == '0) ? BlkW'(1) : cfg_data_i;
    if (32'(cfg_t) > MaxBlocks) begin
      cfg_t = BlkW'(MaxBlocks);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      total_q <= ResetTotal;
      used_q  <= ResetTotal;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        total_q <= cfg_t;
        used_q  <= (used_q > cfg_t) ? cfg_t : used_q;
      end else begin
        used_q  <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    run_q  <= run_d;
    rs_q   <= rs_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    cnt_q  <= cnt_d;
    bsel_q <= bsel_d;
    set_q  <= set_d;
    ok_q   <= ok_d;
    res_q  <= res_d;
  end

  always_comb begin
    logic [BlkW:0] sum;
    state_d = state_q;
    used_d  = used_q;
    blk_d   = blk_q;
    run_d   = run_q;
    rs_d    = rs_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    cnt_d   = cnt_q;
    bsel_d  = bsel_q;
    set_d   = set_q;
    ok_d    = ok_q;
    res_d   = res_q;
    clr_d   = clr_q;
    addr    = AddrW'(blk_q >> 5);
    we      = 1'b0;
    wdata   = set_q ? (rdata | mask) : (rdata & ~mask);
    sum     = {1'b0, used_q} + {1'b0, cnt_q};
    unique case (state_q)
      StClear: begin
        addr  = clr_q;
        we    = 1'b1;
        wdata = '1;
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == Words - 1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cnt_d = block_count_i;
          ok_d  = 1'b0;
          res_d = '0;
          if (mode_i == ModeAlloc) begin
            if (block_count_i != '0 && block_count_i <= total_q - used_q) begin
              blk_d   = '0;
              run_d   = '0;
              rs_d    = '0;
              bsel_d  = '0;
              state_d = StAllocRd;
            end else begin
              state_d = StDone;
            end
          end else if ({1'b0, BlkW'(start_block_i)} + {1'b0, block_count_i}
                       <= {1'b0, total_q}) begin
            lo_d  = BlkW'(start_block_i);
            hi_d  = BlkW'(start_block_i) + block_count_i;
            blk_d = {1'b0, start_block_i[11:5], 5'b00000};
            set_d = (mode_i == ModeReserve);
            ok_d  = 1'b1;
            state_d = (block_count_i == '0) ? StDone : StRangeRd;
          end else begin
            state_d = StDone;
          end
        end
      end
      StAllocRd: begin
        state_d = StAllocScan;
      end
      StAllocScan: begin
        run_d  = scan_out.run;
        rs_d   = scan_out.rs;
        bsel_d = bsel_q + 1'b1;
        if (scan_out.found) begin
          lo_d    = scan_out.rs;
          hi_d    = scan_out.rs + cnt_q;
          blk_d   = {scan_out.rs[BlkW-1:5], 5'b00000};
          set_d   = 1'b1;
          ok_d    = 1'b1;
          res_d   = scan_out.rs[11:0];
          state_d = StRangeRd;
        end else if (scan_out.last) begin
          state_d = StDone;
        end else if (bsel_q == 2'd3) begin
          blk_d   = blk_q + BlkW'(32);
          state_d = StAllocRd;
        end
      end
      StRangeRd: begin
        state_d = StRangeWr;
      end
      StRangeWr: begin
        we    = 1'b1;
        blk_d = blk_q + BlkW'(32);
        if ({1'b0, blk_q} + (BlkW+1)'(32) >= {1'b0, hi_q}) begin
          if (set_q) begin
            used_d = (sum > {1'b0, total_q}) ? total_q : sum[BlkW-1:0];
          end else begin
            used_d = (cnt_q > used_q) ? '0 : used_q - cnt_q;
          end
          state_d = StDone;
        end else begin
          state_d = StRangeRd;
        end
      end
      StDone: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o     = (state_q != StIdle);
  assign out_valid_o    = (state_q == StDone);
  assign ok_o           = ok_q;
  assign result_block_o = res_q;
  assign used_count_o   = used_q;

  `BBA_ASSERT_NOW(a_used_le_total, 1'b1, used_q <= total_q, "used count above total")
  `BBA_ASSERT_NOW(a_refused_zero, out_valid_o && !ok_o, result_block_o == '0, "refused with block")
  `BBA_ASSERT_NOW(a_ready_no_result, !in_stall_o, !out_valid_o, "ready with pending result")
  `BBA_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o, "not busy after request")
endmodule
